### hdl/assert_macros.svh
// Assertion macros used by the coin dispenser datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CICD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CICD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cicd_pkg.sv
// Shared types, constants and coin tables of the coin dispenser.
package cicd_pkg;

    localparam int NKINDS          = 6;
    localparam int DEF_MAX_PAYOUT  = 64;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int KIND_W          = 3;
    localparam int MASK_W          = 6;
    localparam int FIELD_W         = 16;
    localparam int VALUE_W         = 9;
    localparam int IN_DATA_W       = 48;
    localparam int IN_USED_W       = 41;
    localparam int OUT_DATA_W      = 40;

    localparam logic [MASK_W-1:0] EJECT_ALL_MASK = 6'b111111;

    typedef enum logic [2:0] {
        OP_SENSE     = 3'd0,
        OP_PAY       = 3'd1,
        OP_EJECT     = 3'd2,
        OP_EJECT_ALL = 3'd3,
        OP_SET       = 3'd4,
        OP_REPORT    = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_SENSE_SCAN,
        CMD_SENSE_ADD,
        CMD_SENSE_EJECT,
        CMD_PAY_COIN,
        CMD_PAY_NONE,
        CMD_EJECT_ONE,
        CMD_EJECT_ALL,
        CMD_SET_COUNT,
        CMD_REPORT
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t         code;
        logic [KIND_W-1:0] pos;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       kind_ok;
        logic       hit;
        logic       sort;
        logic       fit;
        logic       more;
        logic       n_zero;
        logic       out_free;
    } status_t;

    function automatic logic [VALUE_W-1:0] coin_value(input logic [KIND_W-1:0] k);
        logic [VALUE_W-1:0] v;
        case (k)
            3'd0:    v = 9'd5;
            3'd1:    v = 9'd10;
            3'd2:    v = 9'd20;
            3'd3:    v = 9'd50;
            3'd4:    v = 9'd100;
            3'd5:    v = 9'd200;
            default: v = 9'd385;
        endcase
        return v;
    endfunction

    function automatic logic [MASK_W-1:0] kind_mask(input logic [KIND_W-1:0] k);
        logic [MASK_W-1:0] m;
        case (k)
            3'd0:    m = 6'b000010;
            3'd1:    m = 6'b000001;
            3'd2:    m = 6'b000100;
            3'd3:    m = 6'b010000;
            3'd4:    m = 6'b001000;
            3'd5:    m = 6'b100000;
            default: m = 6'b000000;
        endcase
        return m;
    endfunction

    function automatic logic [KIND_W-1:0] scan_kind(input logic [KIND_W-1:0] p);
        logic [KIND_W-1:0] k;
        case (p)
            3'd0:    k = 3'd5;
            3'd1:    k = 3'd3;
            3'd2:    k = 3'd4;
            3'd3:    k = 3'd2;
            3'd4:    k = 3'd0;
            3'd5:    k = 3'd1;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

endpackage

### hdl/cicd_datapath.sv
// Datapath: coin counts, sensor flags, latched word, payout state and result register.
`include "assert_macros.svh"

module cicd_datapath #(
    parameter int MAX_PAYOUT  = cicd_pkg::DEF_MAX_PAYOUT,
    parameter int COUNT_WIDTH = cicd_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cicd_pkg::cmd_t                        cmd,
    output cicd_pkg::status_t                     st,
    input  logic [cicd_pkg::IN_USED_W-1:0]        in_tdata,
    input  logic [2:0]                            in_tuser,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_data,
    input  logic                                  out_tready,
    output logic                                  out_tvalid,
    output logic [cicd_pkg::OUT_DATA_W-1:0]       out_tdata,
    output logic [cicd_pkg::KIND_W-1:0]           out_tuser,
    output logic                                  out_tlast
);

    localparam int NK = cicd_pkg::NKINDS;
    localparam int KW = cicd_pkg::KIND_W;
    localparam int FW = cicd_pkg::FIELD_W;
    localparam int NW = $clog2(MAX_PAYOUT + 1);
    localparam int VW = (COUNT_WIDTH > FW) ? COUNT_WIDTH : FW;

    logic [COUNT_WIDTH-1:0] counts_reg [NK];
    logic [COUNT_WIDTH-1:0] counts_next [NK];
    logic [NK-1:0]          done_reg, done_next;
    logic                   sort_reg, sort_next;
    logic [2:0]             op_reg, op_next;
    logic [NK-1:0]          levels_reg, levels_next;
    logic [FW-1:0]          amount_reg, amount_next;
    logic [KW-1:0]          kind_reg, kind_next;
    logic [FW-1:0]          value_reg, value_next;
    logic [NW-1:0]          n_reg, n_next;
    logic                   out_valid_reg;
    logic [KW-1:0]          out_kind_reg;
    logic [cicd_pkg::MASK_W-1:0] out_mask_reg;
    logic [FW-1:0]          out_count_reg;
    logic [FW-1:0]          out_rem_reg;
    logic                   out_short_reg;
    logic                   out_last_reg;

    logic [KW-1:0]          sel_kind;
    logic [COUNT_WIDTH-1:0] cnt_sel, cnt_inc, cnt_dec, cnt_set;
    logic [VW-1:0]          value_w, max_w, e_cnt_w;
    logic [NK-1:0]          hit_vec;
    logic                   later;
    logic [KW-1:0]          pk;
    logic [COUNT_WIDTH-1:0] pk_cnt;
    logic                   fit, more_any;
    logic [FW-1:0]          thr, amt_after;
    logic                   avail;

    logic                   e_valid;
    logic [KW-1:0]          e_kind;
    logic [cicd_pkg::MASK_W-1:0] e_mask;
    logic [COUNT_WIDTH-1:0] e_cnt;
    logic [FW-1:0]          e_rem;
    logic                   e_short;
    logic                   e_last;

    always_comb
    begin
        case (cmd.code)
            cicd_pkg::CMD_SENSE_SCAN, cicd_pkg::CMD_SENSE_ADD,
            cicd_pkg::CMD_SENSE_EJECT, cicd_pkg::CMD_REPORT:
                sel_kind = cicd_pkg::scan_kind(cmd.pos);
            cicd_pkg::CMD_PAY_COIN:
                sel_kind = cmd.pos;
            cicd_pkg::CMD_EJECT_ONE, cicd_pkg::CMD_SET_COUNT:
                sel_kind = kind_reg;
            default:
                sel_kind = '0;
        endcase
    end

    assign cnt_sel = (sel_kind < KW'(NK)) ? counts_reg[sel_kind] : '0;
    assign cnt_inc = (&cnt_sel) ? cnt_sel : cnt_sel + COUNT_WIDTH'(1);
    assign cnt_dec = (cnt_sel == '0) ? cnt_sel : cnt_sel - COUNT_WIDTH'(1);
    assign value_w = VW'(value_reg);
    assign max_w   = VW'({COUNT_WIDTH{1'b1}});
    assign cnt_set = (value_w > max_w) ? {COUNT_WIDTH{1'b1}} : value_w[COUNT_WIDTH-1:0];

    // sensor hits in scan order
    always_comb
    begin
        later = 1'b0;
        for (int i = 0; i < NK; i++)
        begin
            hit_vec[i] = !levels_reg[cicd_pkg::scan_kind(KW'(i))]
                         && !done_reg[cicd_pkg::scan_kind(KW'(i))];
            if (KW'(i) > cmd.pos)
                later = later | hit_vec[i];
        end
    end

    // payout fit and lookahead past the current coin
    assign pk        = cmd.pos;
    assign pk_cnt    = (pk < KW'(NK)) ? counts_reg[pk] : '0;
    assign amt_after = amount_reg - FW'(cicd_pkg::coin_value(pk));
    assign fit       = (n_reg < NW'(MAX_PAYOUT))
                       && (amount_reg >= FW'(cicd_pkg::coin_value(pk)))
                       && (pk_cnt != '0);

    always_comb
    begin
        more_any = 1'b0;
        thr      = '0;
        avail    = 1'b0;
        for (int j = 0; j < NK; j++)
        begin
            thr   = FW'(cicd_pkg::coin_value(KW'(j))) + FW'(cicd_pkg::coin_value(pk));
            avail = (KW'(j) == pk) ? (counts_reg[j] > COUNT_WIDTH'(1))
                                   : (counts_reg[j] != '0);
            if (KW'(j) <= pk)
                more_any = more_any | ((amount_reg >= thr) && avail);
        end
    end

    always_comb
    begin
        st.op       = op_reg;
        st.kind_ok  = kind_reg < KW'(NK);
        st.hit      = hit_vec[cmd.pos];
        st.sort     = sort_reg;
        st.fit      = fit;
        st.more     = (n_reg < NW'(MAX_PAYOUT - 1)) && more_any;
        st.n_zero   = (n_reg == '0);
        st.out_free = !out_valid_reg || out_tready;
    end

    always_comb
    begin
        counts_next = counts_reg;
        done_next   = done_reg;
        sort_next   = cfg_valid ? cfg_data : sort_reg;
        op_next     = op_reg;
        levels_next = levels_reg;
        amount_next = amount_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        n_next      = n_reg;
        e_valid     = 1'b0;
        e_kind      = sel_kind;
        e_mask      = '0;
        e_cnt       = cnt_sel;
        e_rem       = '0;
        e_short     = 1'b0;
        e_last      = 1'b1;
        case (cmd.code)
            cicd_pkg::CMD_LOAD:
            begin
                op_next     = in_tuser;
                levels_next = in_tdata[5:0];
                amount_next = in_tdata[21:6];
                kind_next   = in_tdata[24:22];
                value_next  = in_tdata[40:25];
                n_next      = '0;
            end
            cicd_pkg::CMD_SENSE_SCAN:
            begin
                if (levels_reg[sel_kind])
                    done_next[sel_kind] = 1'b0;
            end
            cicd_pkg::CMD_SENSE_ADD:
            begin
                counts_next[sel_kind] = cnt_inc;
                if (!sort_reg)
                    done_next[sel_kind] = 1'b1;
                e_valid = 1'b1;
                e_cnt   = cnt_inc;
                e_last  = !sort_reg && !later;
            end
            cicd_pkg::CMD_SENSE_EJECT:
            begin
                counts_next[sel_kind] = cnt_dec;
                done_next[sel_kind]   = 1'b1;
                e_valid = 1'b1;
                e_mask  = cicd_pkg::kind_mask(sel_kind);
                e_cnt   = cnt_dec;
                e_last  = !later;
            end
            cicd_pkg::CMD_PAY_COIN:
            begin
                counts_next[sel_kind] = cnt_dec;
                amount_next = amt_after;
                n_next      = n_reg + NW'(1);
                e_valid = 1'b1;
                e_mask  = cicd_pkg::kind_mask(sel_kind);
                e_cnt   = cnt_dec;
                e_rem   = amt_after;
                e_last  = !st.more;
                e_short = !st.more && (amt_after != '0);
            end
            cicd_pkg::CMD_PAY_NONE:
            begin
                e_valid = 1'b1;
                e_cnt   = counts_reg[0];
                e_rem   = amount_reg;
                e_short = amount_reg != '0;
            end
            cicd_pkg::CMD_EJECT_ONE:
            begin
                counts_next[sel_kind] = cnt_dec;
                e_valid = 1'b1;
                e_mask  = cicd_pkg::kind_mask(sel_kind);
                e_cnt   = cnt_dec;
            end
            cicd_pkg::CMD_EJECT_ALL:
            begin
                e_valid = 1'b1;
                e_mask  = cicd_pkg::EJECT_ALL_MASK;
                e_cnt   = '0;
            end
            cicd_pkg::CMD_SET_COUNT:
            begin
                counts_next[sel_kind] = cnt_set;
                e_valid = 1'b1;
                e_cnt   = cnt_set;
            end
            cicd_pkg::CMD_REPORT:
            begin
                e_valid = 1'b1;
                e_last  = (cmd.pos == KW'(NK - 1));
            end
            default:
            begin
                e_valid = 1'b0;
            end
        endcase
    end

    assign e_cnt_w = VW'(e_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NK; i++)
                counts_reg[i] <= '0;
            done_reg      <= '0;
            sort_reg      <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            counts_reg    <= counts_next;
            done_reg      <= done_next;
            sort_reg      <= sort_next;
            n_reg         <= n_next;
            out_valid_reg <= e_valid || (out_valid_reg && !out_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        levels_reg <= levels_next;
        amount_reg <= amount_next;
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        if (e_valid)
        begin
            out_kind_reg  <= e_kind;
            out_mask_reg  <= e_mask;
            out_count_reg <= e_cnt_w[FW-1:0];
            out_rem_reg   <= e_rem;
            out_short_reg <= e_short;
            out_last_reg  <= e_last;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tuser  = out_kind_reg;
    assign out_tdata  = {1'b0, out_short_reg, out_rem_reg, out_count_reg, out_mask_reg};
    assign out_tlast  = out_last_reg;

    `CICD_ASSERT(a_emit_free, e_valid |-> (!out_valid_reg || out_tready), "result issued into a busy output register")
    `CICD_ASSERT(a_pay_fit, (cmd.code == cicd_pkg::CMD_PAY_COIN) |-> fit, "coin paid that does not fit")
    `CICD_ASSERT(a_pay_limit, 1'b1 |-> (n_reg <= NW'(MAX_PAYOUT)), "payout coin count beyond limit")
    `CICD_ASSERT_NEXT(a_load_clear, cmd.code == cicd_pkg::CMD_LOAD, n_reg == '0, "payout count not cleared on load")

endmodule

### hdl/cicd_ctrl.sv
// Controller: sequences the steps of each input word over the datapath.
module cicd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_tvalid,
    output logic              in_tready,
    input  cicd_pkg::status_t st,
    output cicd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SENSE,
        S_PAY,
        S_ONE,
        S_REPORT
    } state_t;

    localparam int KW = cicd_pkg::KIND_W;
    localparam logic [KW-1:0] LAST_POS = KW'(cicd_pkg::NKINDS - 1);

    state_t        state_reg, state_next;
    logic [KW-1:0] pos_reg, pos_next;
    logic          sub_reg, sub_next;
    logic          ready_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sub_next   = sub_reg;
        cmd.code   = cicd_pkg::CMD_IDLE;
        cmd.pos    = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_tvalid && ready_reg)
                begin
                    cmd.code   = cicd_pkg::CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                sub_next = 1'b0;
                case (cicd_pkg::op_t'(st.op))
                    cicd_pkg::OP_SENSE:
                    begin
                        pos_next   = '0;
                        state_next = S_SENSE;
                    end
                    cicd_pkg::OP_PAY:
                    begin
                        pos_next   = LAST_POS;
                        state_next = S_PAY;
                    end
                    cicd_pkg::OP_EJECT, cicd_pkg::OP_SET:
                        state_next = st.kind_ok ? S_ONE : S_IDLE;
                    cicd_pkg::OP_EJECT_ALL:
                        state_next = S_ONE;
                    cicd_pkg::OP_REPORT:
                    begin
                        pos_next   = '0;
                        state_next = S_REPORT;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SENSE:
            begin
                if (!st.hit)
                begin
                    cmd.code   = cicd_pkg::CMD_SENSE_SCAN;
                    pos_next   = pos_reg + KW'(1);
                    state_next = (pos_reg == LAST_POS) ? S_IDLE : S_SENSE;
                end
                else if (st.out_free)
                begin
                    if (!sub_reg && st.sort)
                    begin
                        cmd.code = cicd_pkg::CMD_SENSE_ADD;
                        sub_next = 1'b1;
                    end
                    else
                    begin
                        cmd.code   = sub_reg ? cicd_pkg::CMD_SENSE_EJECT
                                             : cicd_pkg::CMD_SENSE_ADD;
                        sub_next   = 1'b0;
                        pos_next   = pos_reg + KW'(1);
                        state_next = (pos_reg == LAST_POS) ? S_IDLE : S_SENSE;
                    end
                end
            end
            S_PAY:
            begin
                if (st.fit)
                begin
                    if (st.out_free)
                    begin
                        cmd.code = cicd_pkg::CMD_PAY_COIN;
                        if (!st.more)
                            state_next = S_IDLE;
                    end
                end
                else if (pos_reg == '0)
                begin
                    if (!st.n_zero)
                        state_next = S_IDLE;
                    else if (st.out_free)
                    begin
                        cmd.code   = cicd_pkg::CMD_PAY_NONE;
                        state_next = S_IDLE;
                    end
                end
                else
                    pos_next = pos_reg - KW'(1);
            end
            S_ONE:
            begin
                if (st.out_free)
                begin
                    case (cicd_pkg::op_t'(st.op))
                        cicd_pkg::OP_EJECT:     cmd.code = cicd_pkg::CMD_EJECT_ONE;
                        cicd_pkg::OP_EJECT_ALL: cmd.code = cicd_pkg::CMD_EJECT_ALL;
                        default:                cmd.code = cicd_pkg::CMD_SET_COUNT;
                    endcase
                    state_next = S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (st.out_free)
                begin
                    cmd.code   = cicd_pkg::CMD_REPORT;
                    pos_next   = pos_reg + KW'(1);
                    state_next = (pos_reg == LAST_POS) ? S_IDLE : S_REPORT;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            sub_reg   <= 1'b0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sub_reg   <= sub_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_tready = ready_reg && (state_reg == S_IDLE);

endmodule

### hdl/coin_inventory_change_dispenser.sv
// Top level of the coin inventory and change dispenser.
//
//  channel   | signals                               | content
//  ----------+---------------------------------------+-----------------------------------
//  s_axis    | tvalid tready tdata[47:0] tuser[2:0]  | command word in, tuser = op
//  m_axis    | tvalid tready tdata[39:0] tuser[2:0]  | result word out, tlast ends a word
//  cfg       | cfg_valid cfg_ready cfg_data          | sort mode, always ready
//
//  One command word at a time: the word is accepted and dispatched, then the
//  controller takes one step per scan position for sense and report (two per
//  sensed coin in sort mode), one step for eject and set, and for payout one
//  step per coin plus one per skipped kind, with at most MAX_PAYOUT coins.
//  A step that makes a result waits while the output register is full.
//  Reset clears all counts, the sensor flags and sort mode.
module coin_inventory_change_dispenser #(
    parameter int MAX_PAYOUT  = cicd_pkg::DEF_MAX_PAYOUT,
    parameter int COUNT_WIDTH = cicd_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sensor_levels[5:0], amount_cents[21:6], coin_kind[24:22], count_value[40:25]
    input  logic [cicd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // op[2:0]
    input  logic [2:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // eject_mask[5:0], kind_count[21:6], remaining_cents[37:22], short_flag[38]
    output logic [cicd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // report_kind[2:0]
    output logic [cicd_pkg::KIND_W-1:0]       m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data
);

    cicd_pkg::cmd_t    cmd;
    cicd_pkg::status_t st;

    cicd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    cicd_datapath #(
        .MAX_PAYOUT  (MAX_PAYOUT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .in_tdata   (s_axis_tdata[cicd_pkg::IN_USED_W-1:0]),
        .in_tuser   (s_axis_tuser),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser),
        .out_tlast  (m_axis_tlast)
    );

    assign cfg_ready = 1'b1;

endmodule

### tb/coin_inventory_change_dispenser_tb.sv
// Self-checking testbench for the coin inventory and change dispenser.
module coin_inventory_change_dispenser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF    = 5;
    localparam int  SETTLE_WAIT = 100;
    localparam int  LONG_HOLD   = 400;
    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam int  PAYOUT_CAP  = cicd_pkg::DEF_MAX_PAYOUT;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam logic [2:0] KIND_5C    = 3'd0;
    localparam logic [2:0] KIND_10C   = 3'd1;
    localparam logic [2:0] KIND_20C   = 3'd2;
    localparam logic [2:0] KIND_50C   = 3'd3;
    localparam logic [2:0] KIND_1EUR  = 3'd4;
    localparam logic [2:0] KIND_2EUR  = 3'd5;
    localparam logic [2:0] KIND_BAD_A = 3'd6;
    localparam logic [2:0] KIND_BAD_B = 3'd7;

    localparam logic [5:0] ALL_COVERED = 6'b000000;
    localparam logic [5:0] ALL_CLEAR   = 6'b111111;

    localparam int          coin_cents [cicd_pkg::NKINDS] = '{5, 10, 20, 50, 100, 200};
    localparam logic [5:0]  eject_bit  [cicd_pkg::NKINDS] = '{6'b000010, 6'b000001,
                                                              6'b000100, 6'b010000,
                                                              6'b001000, 6'b100000};
    localparam logic [2:0]  scan_seq   [cicd_pkg::NKINDS] = '{KIND_2EUR, KIND_50C, KIND_1EUR,
                                                              KIND_20C, KIND_5C, KIND_10C};

    typedef struct {
        logic [2:0]  kind;
        logic [5:0]  mask;
        logic [15:0] count;
        logic [15:0] remaining;
        logic        short_f;
        logic        last_f;
    } coin_word_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  s_axis_tvalid;
    logic                                  s_axis_tready;
    logic [cicd_pkg::IN_DATA_W-1:0]        s_axis_tdata;
    logic [2:0]                            s_axis_tuser;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready;
    logic [cicd_pkg::OUT_DATA_W-1:0]       m_axis_tdata;
    logic [cicd_pkg::KIND_W-1:0]           m_axis_tuser;
    logic                                  m_axis_tlast;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic                                  cfg_data;

    logic [15:0] stock [cicd_pkg::NKINDS];
    logic [5:0]  sensed_done;
    logic        sort_mode_q;
    coin_word_t  coin_words_due [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on     = 1'b1;
    bit          long_hold   = 1'b0;

    coin_inventory_change_dispenser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("coin_inventory_change_dispenser_tb failed");
            $finish;
        end
    end

    function automatic coin_word_t coin_word(input logic [2:0] kind, input logic [5:0] mask,
                                             input logic [15:0] count,
                                             input logic [15:0] remaining,
                                             input logic short_f);
        coin_word_t w;
        w.kind      = kind;
        w.mask      = mask;
        w.count     = count;
        w.remaining = remaining;
        w.short_f   = short_f;
        w.last_f    = 1'b0;
        return w;
    endfunction

    function automatic void predict_dispense(input logic [2:0] op, input logic [5:0] levels,
                                             input logic [15:0] amount,
                                             input logic [2:0] kind,
                                             input logic [15:0] value);
        coin_word_t  words [$];
        coin_word_t  w;
        logic [15:0] left;
        int          k;
        left = amount;
        case (op)
            cicd_pkg::OP_SENSE:
                for (int i = 0; i < cicd_pkg::NKINDS; i++)
                begin
                    k = scan_seq[i];
                    if (!levels[k])
                    begin
                        if (!sensed_done[k])
                        begin
                            if (stock[k] != COUNT_TOP)
                                stock[k] = stock[k] + 16'd1;
                            words.push_back(coin_word(3'(k), 6'b0, stock[k], 16'd0, 1'b0));
                            if (sort_mode_q)
                            begin
                                if (stock[k] != 16'd0)
                                    stock[k] = stock[k] - 16'd1;
                                words.push_back(coin_word(3'(k), eject_bit[k], stock[k],
                                                          16'd0, 1'b0));
                            end
                            sensed_done[k] = 1'b1;
                        end
                    end
                    else
                        sensed_done[k] = 1'b0;
                end
            cicd_pkg::OP_PAY:
            begin
                for (k = cicd_pkg::NKINDS - 1; k >= 0; k--)
                    while (words.size() < PAYOUT_CAP && int'(left) >= coin_cents[k]
                           && stock[k] != 16'd0)
                    begin
                        stock[k] = stock[k] - 16'd1;
                        left     = left - 16'(coin_cents[k]);
                        words.push_back(coin_word(3'(k), eject_bit[k], stock[k], left, 1'b0));
                    end
                if (words.size() == 0)
                    words.push_back(coin_word(KIND_5C, 6'b0, stock[0], left, left != 16'd0));
                else
                begin
                    w = words[words.size() - 1];
                    w.short_f = (left != 16'd0);
                    words[words.size() - 1] = w;
                end
            end
            cicd_pkg::OP_EJECT:
                if (kind < cicd_pkg::NKINDS)
                begin
                    if (stock[kind] != 16'd0)
                        stock[kind] = stock[kind] - 16'd1;
                    words.push_back(coin_word(kind, eject_bit[kind], stock[kind], 16'd0, 1'b0));
                end
            cicd_pkg::OP_EJECT_ALL:
                words.push_back(coin_word(KIND_5C, cicd_pkg::EJECT_ALL_MASK, 16'd0, 16'd0,
                                          1'b0));
            cicd_pkg::OP_SET:
                if (kind < cicd_pkg::NKINDS)
                begin
                    stock[kind] = value;
                    words.push_back(coin_word(kind, 6'b0, stock[kind], 16'd0, 1'b0));
                end
            cicd_pkg::OP_REPORT:
                for (int i = 0; i < cicd_pkg::NKINDS; i++)
                    words.push_back(coin_word(scan_seq[i], 6'b0, stock[scan_seq[i]],
                                              16'd0, 1'b0));
            default:
                ;
        endcase
        if (words.size() > 0)
        begin
            w = words[words.size() - 1];
            w.last_f = 1'b1;
            words[words.size() - 1] = w;
        end
        foreach (words[i])
            coin_words_due.push_back(words[i]);
    endfunction

    always @(posedge clk)
    begin : check_words
        coin_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (coin_words_due.size() == 0)
            begin
                $error("unexpected result word: kind %0d mask %b count %0d",
                       m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6]);
                error_count++;
            end
            else
            begin
                want = coin_words_due.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    $error("report_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[5:0] !== want.mask)
                begin
                    $error("eject_mask: expected %b, got %b", want.mask, m_axis_tdata[5:0]);
                    error_count++;
                end
                if (m_axis_tdata[21:6] !== want.count)
                begin
                    $error("kind_count: expected %0d, got %0d", want.count, m_axis_tdata[21:6]);
                    error_count++;
                end
                if (m_axis_tdata[37:22] !== want.remaining)
                begin
                    $error("remaining_cents: expected %0d, got %0d",
                           want.remaining, m_axis_tdata[37:22]);
                    error_count++;
                end
                if (m_axis_tdata[38] !== want.short_f)
                begin
                    $error("short_flag: expected %0b, got %0b", want.short_f, m_axis_tdata[38]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last_f)
                begin
                    $error("last: expected %0b, got %0b", want.last_f, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold)
            begin
                long_hold     = 1'b0;
                stall_left    = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_left    = $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [5:0] levels,
                             input logic [15:0] amount, input logic [2:0] kind,
                             input logic [15:0] value);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, value, kind, amount, levels};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        predict_dispense(op, levels, amount, kind, value);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (coin_words_due.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_sort_mode(input logic mode);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        sort_mode_q = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_word();
        int          pick;
        logic [2:0]  op;
        logic [5:0]  levels;
        logic [15:0] amount;
        logic [15:0] value;
        logic [2:0]  kind;
        pick   = $urandom_range(0, 99);
        levels = 6'($urandom);
        kind   = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        amount = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1200));
        value  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
        if (pick < 35)
            op = cicd_pkg::OP_SENSE;
        else if (pick < 60)
            op = cicd_pkg::OP_PAY;
        else if (pick < 70)
            op = cicd_pkg::OP_EJECT;
        else if (pick < 75)
            op = cicd_pkg::OP_EJECT_ALL;
        else if (pick < 87)
            op = cicd_pkg::OP_SET;
        else if (pick < 95)
            op = cicd_pkg::OP_REPORT;
        else
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        send_word(op, levels, amount, kind, value);
    endtask

    task automatic test_inventory_commands();
        send_word(cicd_pkg::OP_REPORT, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_EJECT_ALL, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_EJECT, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_EJECT, ALL_CLEAR, 16'd0, KIND_BAD_B, 16'd0);
        send_word(cicd_pkg::OP_SET, ALL_CLEAR, 16'd0, KIND_BAD_A, 16'hFFFF);
        send_word(OP_SPARE_A, ALL_COVERED, 16'hFFFF, KIND_BAD_B, 16'hFFFF);
        send_word(OP_SPARE_B, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_SET, ALL_CLEAR, 16'd0, KIND_2EUR, 16'hFFFF);
        send_word(cicd_pkg::OP_SET, ALL_CLEAR, 16'd0, KIND_5C, 16'd100);
    endtask

    task automatic test_coin_sensing();
        send_word(cicd_pkg::OP_SENSE, ALL_COVERED, 16'd0, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_SENSE, ALL_COVERED, 16'd0, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_SENSE, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
        write_sort_mode(1'b1);
        send_word(cicd_pkg::OP_SENSE, 6'b010101, 16'd0, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_SENSE, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
        write_sort_mode(1'b0);
    endtask

    task automatic test_payout();
        send_word(cicd_pkg::OP_PAY, ALL_CLEAR, 16'hFFFF, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_PAY, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_PAY, ALL_CLEAR, 16'd3, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_PAY, ALL_CLEAR, 16'd385, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_SET, ALL_CLEAR, 16'd0, KIND_50C, 16'd0);
        send_word(cicd_pkg::OP_PAY, ALL_CLEAR, 16'd50, KIND_5C, 16'd0);
        send_word(cicd_pkg::OP_REPORT, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
    endtask

    task automatic test_random_traffic(input int words);
        repeat (words) send_random_word();
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        repeat (12) send_word(cicd_pkg::OP_REPORT, ALL_CLEAR, 16'd0, KIND_5C, 16'd0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        foreach (stock[i])
            stock[i] = 16'd0;
        sensed_done = 6'b0;
        sort_mode_q = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_inventory_commands();
        test_coin_sensing();
        test_payout();
        write_sort_mode(1'b0);
        test_random_traffic(100);
        write_sort_mode(1'b1);
        test_random_traffic(80);
        test_backpressure();
        gaps_on = 1'b0;
        write_sort_mode(1'b0);
        test_random_traffic(70);
        settle();

        if (error_count == 0)
            $display("coin_inventory_change_dispenser_tb passed");
        else
            $display("coin_inventory_change_dispenser_tb failed");
        $finish;
    end

endmodule
